/* hdl/png_stream_end_finder_core_assert.svh */
// ----------------------------------------------------------------------------
// png_stream_end_finder_core_assert.svh
// Assertion macros for the PNG stream end finder
// ----------------------------------------------------------------------------
`ifndef PNG_STREAM_END_FINDER_CORE_ASSERT_SVH
`define PNG_STREAM_END_FINDER_CORE_ASSERT_SVH

// same-cycle implication
`define PSEF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSEF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/psef_pkg.sv */
// ----------------------------------------------------------------------------
// psef_pkg
// Types, codes and constant tables for the PNG stream end finder
// ----------------------------------------------------------------------------
package psef_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_start;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  parse_status;
		logic [31:0] end_offset;
	} out_word_t;

	typedef enum logic [2:0] {
		PH_SIGNATURE = 3'd0,
		PH_LENGTH    = 3'd1,
		PH_TYPE      = 3'd2,
		PH_SKIP      = 3'd3,
		PH_DONE      = 3'd4,
		PH_ERROR     = 3'd5
	} phase_t;

	localparam logic [1:0] ST_PARSING  = 2'd0;
	localparam logic [1:0] ST_END      = 2'd1;
	localparam logic [1:0] ST_BADSIG   = 2'd2;
	localparam logic [1:0] ST_TRAILING = 2'd3;

	localparam logic [31:0] CHUNK_CRC_BYTES = 32'd4;

	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h89;
			3'd1: b = 8'h50;
			3'd2: b = 8'h4E;
			3'd3: b = 8'h47;
			3'd4: b = 8'h0D;
			3'd5: b = 8'h0A;
			3'd6: b = 8'h1A;
			3'd7: b = 8'h0A;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] iend_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h49;
			2'd1: b = 8'h45;
			2'd2: b = 8'h4E;
			2'd3: b = 8'h44;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* hdl/psef_parser.sv */
// ----------------------------------------------------------------------------
// psef_parser
// Parse state registers and per-byte next-state and result logic
// ----------------------------------------------------------------------------
module psef_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  psef_pkg::in_word_t  word,
	output psef_pkg::out_word_t result
);

	psef_pkg::phase_t phase_q, cur_phase, nxt_phase;
	logic [2:0]  idx_q, cur_idx, nxt_idx;
	logic [31:0] len_q, cur_len, nxt_len;
	logic        iend_q, cur_iend, nxt_iend;
	logic [31:0] skip_q, cur_skip, nxt_skip;
	logic [31:0] pos_q, cur_pos, nxt_pos;
	logic [31:0] skip_init, skip_dec;
	logic [7:0]  b;
	logic [1:0]  status;
	logic        iend_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= psef_pkg::PH_SIGNATURE;
			idx_q   <= '0;
			len_q   <= '0;
			iend_q  <= 1'b0;
			skip_q  <= '0;
			pos_q   <= '0;
		end else if (take) begin
			phase_q <= nxt_phase;
			idx_q   <= nxt_idx;
			len_q   <= nxt_len;
			iend_q  <= nxt_iend;
			skip_q  <= nxt_skip;
			pos_q   <= nxt_pos;
		end
	end

	always_comb begin
		b         = word.data_byte;
		cur_phase = word.stream_start ? psef_pkg::PH_SIGNATURE : phase_q;
		cur_idx   = word.stream_start ? 3'd0 : idx_q;
		cur_len   = word.stream_start ? 32'd0 : len_q;
		cur_iend  = word.stream_start ? 1'b0 : iend_q;
		cur_skip  = word.stream_start ? 32'd0 : skip_q;
		cur_pos   = word.stream_start ? 32'd0 : pos_q;

		nxt_phase = cur_phase;
		nxt_idx   = cur_idx;
		nxt_len   = cur_len;
		nxt_iend  = cur_iend;
		nxt_skip  = cur_skip;
		nxt_pos   = (cur_pos == '1) ? cur_pos : cur_pos + 32'd1;
		status    = psef_pkg::ST_PARSING;

		skip_init  = cur_len + psef_pkg::CHUNK_CRC_BYTES;
		skip_dec   = cur_skip - 32'd1;
		iend_match = (b == psef_pkg::iend_byte(cur_idx[1:0]));

		case (cur_phase)
			psef_pkg::PH_SIGNATURE: begin
				if (b != psef_pkg::sig_byte(cur_idx)) begin
					nxt_phase = psef_pkg::PH_ERROR;
					status    = psef_pkg::ST_BADSIG;
				end else if (cur_idx == 3'd7) begin
					nxt_phase = psef_pkg::PH_LENGTH;
					nxt_idx   = 3'd0;
					nxt_len   = '0;
				end else begin
					nxt_idx = cur_idx + 3'd1;
				end
			end
			psef_pkg::PH_LENGTH: begin
				nxt_len = {cur_len[23:0], b};
				if (cur_idx[1:0] == 2'd3) begin
					nxt_phase = psef_pkg::PH_TYPE;
					nxt_idx   = 3'd0;
					nxt_iend  = 1'b0;
				end else begin
					nxt_idx = {1'b0, cur_idx[1:0]} + 3'd1;
				end
			end
			psef_pkg::PH_TYPE: begin
				if (cur_idx[1:0] == 2'd0)
					nxt_iend = iend_match;
				else
					nxt_iend = cur_iend & iend_match;
				if (cur_idx[1:0] == 2'd3) begin
					nxt_idx  = 3'd0;
					nxt_skip = skip_init;
					if (skip_init == 32'd0) begin
						if (nxt_iend) begin
							nxt_phase = psef_pkg::PH_DONE;
							status    = psef_pkg::ST_END;
						end else begin
							nxt_phase = psef_pkg::PH_LENGTH;
							nxt_len   = '0;
						end
					end else begin
						nxt_phase = psef_pkg::PH_SKIP;
					end
				end else begin
					nxt_idx = {1'b0, cur_idx[1:0]} + 3'd1;
				end
			end
			psef_pkg::PH_SKIP: begin
				nxt_skip = skip_dec;
				if (skip_dec == 32'd0) begin
					if (cur_iend) begin
						nxt_phase = psef_pkg::PH_DONE;
						status    = psef_pkg::ST_END;
					end else begin
						nxt_phase = psef_pkg::PH_LENGTH;
						nxt_idx   = 3'd0;
						nxt_len   = '0;
					end
				end
			end
			psef_pkg::PH_DONE: begin
				status = psef_pkg::ST_TRAILING;
			end
			default: begin
				status = psef_pkg::ST_BADSIG;
			end
		endcase

		result.parse_status = status;
		result.end_offset   = (status == psef_pkg::ST_END) ? nxt_pos : 32'd0;
	end

endmodule

/* hdl/psef_out_buf.sv */
// ----------------------------------------------------------------------------
// psef_out_buf
// Result register with skid stage between parser and output channel
// ----------------------------------------------------------------------------
module psef_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  psef_pkg::out_word_t push_word,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output psef_pkg::out_word_t out_word
);

	logic                out_valid_q;
	logic                skid_valid_q;
	psef_pkg::out_word_t out_q;
	psef_pkg::out_word_t skid_q;
	logic                pop;

	assign pop = out_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= push_word;
		end else if (push) begin
			skid_q <= push_word;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

/* hdl/png_stream_end_finder_core.sv */
// ----------------------------------------------------------------------------
// png_stream_end_finder_core
// Byte-wide PNG signature check and chunk walker reporting the stream length
// ----------------------------------------------------------------------------
// Takes one stream byte per clock while byte_stall is low and returns one
// result word per byte via the output register, or the skid register if the
// output is stalled. The next parse state (32-bit length add and skip count
// decrement) is combinational. A two-entry output register and skid stage
// decouple the sides; byte_stall rises only when both hold untaken results.

`include "png_stream_end_finder_core_assert.svh"

module png_stream_end_finder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  psef_pkg::in_word_t  byte_word,
	output logic                result_valid,
	input  logic                result_stall,
	output psef_pkg::out_word_t result_word
);

	logic                take;
	logic                full;
	psef_pkg::out_word_t parse_result;

	assign byte_stall = full;
	assign take       = byte_valid & ~full;

	psef_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.word   (byte_word),
		.result (parse_result)
	);

	psef_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_word (parse_result),
		.full      (full),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_word  (result_word)
	);

	`PSEF_ASSERT_NOW(a_end_has_offset, result_valid && result_word.parse_status == psef_pkg::ST_END, result_word.end_offset != 32'd0, "end result without offset")
	`PSEF_ASSERT_NOW(a_offset_only_at_end, result_valid && result_word.parse_status != psef_pkg::ST_END, result_word.end_offset == 32'd0, "offset on non-end result")
	`PSEF_ASSERT_NEXT(a_taken_gives_result, take, result_valid, "taken byte produced no result")

endmodule

/* bench/png_stream_end_finder_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_stream_end_finder_core_tb
// Self-checking bench for the PNG stream end finder
// ----------------------------------------------------------------------------
// Byte words go in over the valid/stall handshake. Each result word is checked
// field by field against its row's typed expectation, else a chunk walker in
// the bench. A short hand-picked byte table runs first; random PNG streams
// follow with noise and cut-offs, in three idling patterns on both sides.
// ----------------------------------------------------------------------------
module png_stream_end_finder_core_tb;
	import psef_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       start;
		bit         typed;
		out_word_t  want;
	} table_row_t;

	localparam int          WORD_TARGET = 1850;
	localparam int          CYCLE_LIMIT = 400000;
	localparam logic [63:0] PNG_MAGIC   = 64'h8950_4E47_0D0A_1A0A;
	localparam logic [31:0] IEND_TAG    = 32'h4945_4E44;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_stall;
	in_word_t  byte_word;
	logic      result_valid;
	logic      result_stall;
	out_word_t result_word;

	// expectation typed into the table, travels with the word
	bit        word_typed;
	out_word_t word_want;

	phase_t      walk_phase;
	logic [2:0]  walk_field;
	logic [31:0] walk_len;
	logic        walk_iend;
	logic [31:0] walk_skip;
	logic [31:0] walk_pos;

	out_word_t  status_due[$];
	table_row_t plan[$];

	int send_idle_pct;
	int recv_stall_pct;
	int words_sent;
	int results_seen;
	int mismatches;
	int cycles;
	int ends_seen;
	int badsig_seen;
	int trailing_seen;

	png_stream_end_finder_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_word   (byte_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_word (result_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [1:0] close_chunk();
		if (walk_iend) begin
			walk_phase = PH_DONE;
			return ST_END;
		end
		walk_phase = PH_LENGTH;
		walk_field = 3'd0;
		walk_len   = 32'd0;
		return ST_PARSING;
	endfunction

	function automatic out_word_t walk_png_byte(in_word_t w);
		out_word_t  r;
		logic [1:0] st;
		logic [2:0] ix;
		logic [1:0] tx;
		st = ST_PARSING;
		if (w.stream_start) begin
			walk_phase = PH_SIGNATURE;
			walk_field = 3'd0;
			walk_len   = 32'd0;
			walk_iend  = 1'b0;
			walk_skip  = 32'd0;
			walk_pos   = 32'd0;
		end
		if (walk_pos != 32'hFFFF_FFFF)
			walk_pos = walk_pos + 32'd1;
		ix = walk_field;
		tx = ix[1:0];
		case (walk_phase)
			PH_SIGNATURE: begin
				if (w.data_byte != PNG_MAGIC[63 - 8 * int'(ix) -: 8]) begin
					walk_phase = PH_ERROR;
					st = ST_BADSIG;
				end else if (ix == 3'd7) begin
					walk_phase = PH_LENGTH;
					walk_field = 3'd0;
					walk_len   = 32'd0;
				end else begin
					walk_field = ix + 3'd1;
				end
			end
			PH_LENGTH: begin
				walk_len = {walk_len[23:0], w.data_byte};
				if (tx == 2'd3) begin
					walk_phase = PH_TYPE;
					walk_field = 3'd0;
					walk_iend  = 1'b0;
				end else begin
					walk_field = {1'b0, tx} + 3'd1;
				end
			end
			PH_TYPE: begin
				if (tx == 2'd0)
					walk_iend = (w.data_byte == IEND_TAG[31:24]);
				else
					walk_iend = walk_iend && (w.data_byte == IEND_TAG[31 - 8 * int'(tx) -: 8]);
				if (tx == 2'd3) begin
					walk_field = 3'd0;
					walk_skip  = walk_len + CHUNK_CRC_BYTES;
					if (walk_skip == 32'd0)
						st = close_chunk();
					else
						walk_phase = PH_SKIP;
				end else begin
					walk_field = {1'b0, tx} + 3'd1;
				end
			end
			PH_SKIP: begin
				walk_skip = walk_skip - 32'd1;
				if (walk_skip == 32'd0)
					st = close_chunk();
			end
			PH_DONE: st = ST_TRAILING;
			default: st = ST_BADSIG;
		endcase
		r.parse_status = st;
		r.end_offset   = (st == ST_END) ? walk_pos : 32'd0;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= 20)
			$display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
	endtask

	always @(posedge clk) begin
		out_word_t due;
		out_word_t model;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d words due", cycles, status_due.size());
			$display("Some tests failed");
			$finish;
		end
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				model = walk_png_byte(byte_word);
				status_due.push_back(word_typed ? word_want : model);
			end
			if (result_valid && !result_stall) begin
				results_seen++;
				if (status_due.size() == 0) begin
					report_mismatch("result word with nothing due", result_word.end_offset, 32'd0);
				end else begin
					due = status_due.pop_front();
					if (result_word.parse_status !== due.parse_status)
						report_mismatch("parse_status", 32'(result_word.parse_status),
							32'(due.parse_status));
					if (result_word.end_offset !== due.end_offset)
						report_mismatch("end_offset", result_word.end_offset, due.end_offset);
					case (due.parse_status)
						ST_END:      ends_seen++;
						ST_BADSIG:   badsig_seen++;
						ST_TRAILING: trailing_seen++;
						default: ;
					endcase
				end
			end
		end
	end

	always @(negedge clk)
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	task automatic send_word(logic [7:0] data, logic start, bit typed, out_word_t want);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_word  <= '{data_byte: data, stream_start: start};
		word_typed <= typed;
		word_want  <= want;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic feed(logic [7:0] data, logic start);
		send_word(data, start, 1'b0, '0);
	endtask

	task automatic add_row(logic [7:0] data, logic start, bit typed, logic [1:0] st,
			logic [31:0] offset);
		table_row_t row;
		row.data              = data;
		row.start             = start;
		row.typed             = typed;
		row.want.parse_status = st;
		row.want.end_offset   = offset;
		plan.push_back(row);
	endtask

	task automatic drain();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (status_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_png_stream();
		logic [7:0]  bytes[$];
		logic [31:0] len;
		logic [31:0] tag;
		logic [31:0] skip;
		int          n_chunks;
		int          flip;
		int          cut;
		bytes = {};
		for (int i = 0; i < 8; i++)
			bytes.push_back(PNG_MAGIC[63 - 8 * i -: 8]);
		if ($urandom_range(0, 19) == 0) begin
			flip = $urandom_range(0, 7);
			bytes[flip] = bytes[flip] ^ (8'h01 << $urandom_range(0, 7));
		end
		n_chunks = $urandom_range(0, 3);
		for (int c = 0; c <= n_chunks; c++) begin
			case ($urandom_range(0, 9))
				0: len = 32'd0;
				1: len = 32'hFFFF_FFFC + $urandom_range(0, 3);
				2: len = $urandom_range(13, 40);
				default: len = $urandom_range(1, 12);
			endcase
			if (c == n_chunks)
				tag = IEND_TAG;
			else if ($urandom_range(0, 2) == 0)
				tag = IEND_TAG ^ (32'h1 << $urandom_range(0, 31));
			else
				tag = $urandom;
			for (int i = 0; i < 4; i++)
				bytes.push_back(len[31 - 8 * i -: 8]);
			for (int i = 0; i < 4; i++)
				bytes.push_back(tag[31 - 8 * i -: 8]);
			skip = len + CHUNK_CRC_BYTES;
			for (int i = 0; i < int'(skip); i++)
				bytes.push_back(8'($urandom));
		end
		repeat ($urandom_range(0, 4))
			bytes.push_back(8'($urandom));
		// cut-off stream, the next start must recover
		if ($urandom_range(0, 14) == 0) begin
			cut = $urandom_range(1, bytes.size() - 1);
			while (bytes.size() > cut)
				void'(bytes.pop_back());
		end
		foreach (bytes[i])
			feed(bytes[i], i == 0 && $urandom_range(0, 19) != 0);
	endtask

	initial begin
		int mode;
		arst_n         = 1'b0;
		byte_valid     = 1'b0;
		byte_word      = '0;
		word_typed     = 1'b0;
		word_want      = '0;
		send_idle_pct  = 11;
		recv_stall_pct = 69;
		words_sent     = 0;
		results_seen   = 0;
		mismatches     = 0;
		cycles         = 0;
		ends_seen      = 0;
		badsig_seen    = 0;
		trailing_seen  = 0;
		mode           = 0;
		walk_phase     = PH_SIGNATURE;
		walk_field     = 3'd0;
		walk_len       = 32'd0;
		walk_iend      = 1'b0;
		walk_skip      = 32'd0;
		walk_pos       = 32'd0;

		// no start after reset, then a sticky bad signature
		add_row(8'h89, 1'b0, 1'b1, ST_PARSING, 32'd0);
		add_row(8'h00, 1'b0, 1'b1, ST_BADSIG, 32'd0);
		add_row(8'hFF, 1'b0, 1'b1, ST_BADSIG, 32'd0);
		for (int i = 0; i < 8; i++)
			add_row(PNG_MAGIC[63 - 8 * i -: 8], i == 0, 1'b1, ST_PARSING, 32'd0);
		// zero skip count on an end chunk, then trailing bytes and a bad restart
		add_row(8'hFF, 1'b0, 1'b0, ST_PARSING, 32'd0);
		add_row(8'hFF, 1'b0, 1'b0, ST_PARSING, 32'd0);
		add_row(8'hFF, 1'b0, 1'b0, ST_PARSING, 32'd0);
		add_row(8'hFC, 1'b0, 1'b0, ST_PARSING, 32'd0);
		add_row(IEND_TAG[31:24], 1'b0, 1'b0, ST_PARSING, 32'd0);
		add_row(IEND_TAG[23:16], 1'b0, 1'b0, ST_PARSING, 32'd0);
		add_row(IEND_TAG[15:8], 1'b0, 1'b0, ST_PARSING, 32'd0);
		add_row(IEND_TAG[7:0], 1'b0, 1'b1, ST_END, 32'd16);
		add_row(8'hFF, 1'b0, 1'b1, ST_TRAILING, 32'd0);
		add_row(8'h00, 1'b0, 1'b1, ST_TRAILING, 32'd0);
		add_row(8'h00, 1'b1, 1'b1, ST_BADSIG, 32'd0);

		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i])
			send_word(plan[i].data, plan[i].start, plan[i].typed, plan[i].want);

		while (words_sent < WORD_TARGET) begin
			if (mode == 0 && words_sent >= WORD_TARGET / 3) begin
				drain();
				send_idle_pct  = 69;
				recv_stall_pct = 11;
				mode = 1;
			end else if (mode == 1 && words_sent >= 2 * WORD_TARGET / 3) begin
				drain();
				send_idle_pct  = 0;
				recv_stall_pct = 0;
				mode = 2;
			end
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 12))
					feed(8'($urandom), 1'($urandom_range(0, 1)));
			else
				send_png_stream();
		end

		drain();
		repeat (8)
			@(posedge clk);
		$display("covered %0d byte words, %0d results", words_sent, results_seen);
		$display("%0d stream ends, %0d bad signature, %0d trailing",
			ends_seen, badsig_seen, trailing_seen);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
